// ----- rtl/lbpm_pkg.sv -----
// Shared types and constants for the LED bar progress meter.
package lbpm_pkg;

    localparam int COUNT_W  = 32;
    localparam int VALUE_W  = 33;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 2;
    localparam int OUT_LEDS = 8;
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 56;

    typedef enum logic [1:0] {
        FUNC_SET     = 2'd0,
        FUNC_ADD     = 2'd1,
        FUNC_REFRESH = 2'd2
    } func_t;

    typedef enum logic [IDX_W-1:0] {
        REG_TOTAL = 2'd0,
        REG_BLINK = 2'd1,
        REG_ROUND = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLAMP = 5'b00010,
        S_LOAD  = 5'b00100,
        S_DIV   = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

endpackage

// ----- rtl/led_bar_progress_meter_unit.sv -----
// LED bar progress meter: running count, clamp, bit-serial divide and LED pattern.
// An accepted item passes S_CLAMP, S_LOAD, S_DIV and S_FIN before m_tvalid rises, QW = clog2(LED_COUNT+1).
// A new item is taken only in S_IDLE, once the last one has left S_FIN; the restoring divider
// gives one quotient bit per cycle; a finished item waits in S_FIN until the output register is free.
// Reset (rst_n low, asynchronous) clears the count, shown lit count and control state,
// and sets total_count = 0, blink_partial = 0, round_up = 1.
module led_bar_progress_meter_unit
    import lbpm_pkg::*;
#(
    parameter int LED_COUNT = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [32:0] value, [39:33] zero
    input  logic [S_USER_W-1:0] s_tuser,   // [1:0] func, [2] force_req
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [3:0] lit_count, [6:4] partial_index,
                                           // [14:7] on_mask, [22:15] blink_mask,
                                           // [54:23] count_now, [55] zero
    output logic                m_tuser    // [0] refreshed
);

    localparam int QW = $clog2(LED_COUNT + 1);
    localparam int PW = COUNT_W + QW;
    localparam int SW = $clog2(QW + 1);

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    logic                blink_partial_reg, blink_partial_next;
    logic                round_up_reg, round_up_next;
    logic [3:0]          shown_reg, shown_next;
    logic                force_reg, force_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [COUNT_W-1:0]  clamp_reg, clamp_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic [SW-1:0]       step_reg, step_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_user_reg, out_user_next;

    logic [PW-1:0]       prod;
    logic [COUNT_W:0]    trial;
    logic [COUNT_W:0]    trial_diff;
    logic                qbit;
    logic [QW:0]         quo_shift;
    logic                rnz;
    logic                up;
    logic                went_down;
    logic [QW-1:0]       lit;
    logic [QW-1:0]       partial;
    logic [31:0]         lit_ext;
    logic [31:0]         part_ext;
    logic [OUT_LEDS-1:0] on_mask;
    logic [OUT_LEDS-1:0] blink_mask;
    logic                refreshed;
    func_t               func_in;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign func_in  = func_t'(s_tuser[1:0]);

    assign prod       = PW'(clamp_reg) * PW'(LED_COUNT);
    assign trial      = {rem_reg, quo_reg[QW-1]};
    assign trial_diff = trial - {1'b0, total_reg};
    assign qbit       = (trial >= {1'b0, total_reg});
    assign quo_shift  = {quo_reg, qbit};

    always_comb
    begin
        rnz = (rem_reg != '0);
        if (round_up_reg)
        begin
            up = rnz;
        end
        else
        begin
            up = ({rem_reg, 1'b0} >= {1'b0, total_reg});
        end
        if (total_reg == '0)
        begin
            lit       = QW'(LED_COUNT);
            went_down = 1'b0;
        end
        else
        begin
            lit       = quo_reg + QW'(up);
            went_down = rnz && !up;
        end
        if (went_down)
        begin
            partial = lit;
        end
        else if (lit != '0)
        begin
            partial = lit - QW'(1);
        end
        else
        begin
            partial = '0;
        end
        lit_ext  = 32'(lit);
        part_ext = 32'(partial);
        on_mask    = '0;
        blink_mask = '0;
        for (int i = 0; i < OUT_LEDS; i++)
        begin
            if (i < LED_COUNT)
            begin
                blink_mask[i] = blink_partial_reg && (lit != '0) && (int'(partial) == i);
                on_mask[i]    = (lit != '0) && !blink_mask[i] && (int'(lit) > i);
            end
        end
        if ((lit == '0) && blink_partial_reg)
        begin
            blink_mask[0] = 1'b1;
        end
        refreshed = force_reg || (shown_reg != lit_ext[3:0]);
    end

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        total_next         = total_reg;
        blink_partial_next = blink_partial_reg;
        round_up_next      = round_up_reg;
        shown_next         = shown_reg;
        force_next         = force_reg;
        m_tvalid_next      = m_tvalid_reg;
        clamp_next         = clamp_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        step_next          = step_reg;
        out_data_next      = out_data_reg;
        out_user_next      = out_user_reg;

        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TOTAL: total_next         = cfg_wdata[COUNT_W-1:0];
                REG_BLINK: blink_partial_next = cfg_wdata[0];
                REG_ROUND: round_up_next      = cfg_wdata[0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    force_next = s_tuser[2];
                    state_next = S_CLAMP;
                    unique case (func_in)
                        FUNC_SET:
                        begin
                            count_next = s_tdata[VALUE_W-1] ? '0 : s_tdata[COUNT_W-1:0];
                        end
                        FUNC_ADD:
                        begin
                            count_next = count_reg + s_tdata[COUNT_W-1:0];
                        end
                        default: ;
                    endcase
                end
            end
            S_CLAMP:
            begin
                clamp_next = (count_reg < total_reg) ? count_reg : total_reg;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                rem_next   = prod[PW-1:QW];
                quo_next   = prod[QW-1:0];
                step_next  = SW'(QW);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = qbit ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
                quo_next  = quo_shift[QW-1:0];
                step_next = step_reg - SW'(1);
                if (step_reg == SW'(1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_data_next = {1'b0, count_reg, blink_mask, on_mask,
                                     part_ext[2:0], lit_ext[3:0]};
                    out_user_next = refreshed;
                    m_tvalid_next = 1'b1;
                    if (refreshed)
                    begin
                        shown_next = lit_ext[3:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            total_reg         <= '0;
            blink_partial_reg <= 1'b0;
            round_up_reg      <= 1'b1;
            shown_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
            step_reg          <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            total_reg         <= total_next;
            blink_partial_reg <= blink_partial_next;
            round_up_reg      <= round_up_next;
            shown_reg         <= shown_next;
            m_tvalid_reg      <= m_tvalid_next;
            step_reg          <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        force_reg    <= force_next;
        clamp_reg    <= clamp_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_CLAMP))
        else $error("accepted item did not start processing");

    a_blink_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> $onehot0(out_data_reg[22:15]))
        else $error("blink mask has more than one bit set");

    a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> ((out_data_reg[14:7] & out_data_reg[22:15]) == '0))
        else $error("LED both steady and blinking");

    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (step_reg != '0))
        else $error("divider step counter underflow");

endmodule

// ----- bench/led_bar_progress_meter_unit_tb.sv -----
// Self-checking bench for the LED bar progress meter: random and directed items, predicted patterns.
`timescale 1ns / 100ps

module led_bar_progress_meter_unit_tb;
    import lbpm_pkg::*;

    localparam int LEDS        = 8;
    localparam int NUM_PHASES  = 15;
    localparam int RAND_ITEMS  = 142;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [32:0] value;
        logic               force_req;
    } meter_item_t;

    typedef struct packed {
        logic [3:0]  lit_count;
        logic [2:0]  partial_index;
        logic [7:0]  on_mask;
        logic [7:0]  blink_mask;
        logic        refreshed;
        logic [31:0] count_now;
    } bar_pattern_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = REG_TOTAL;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    meter_item_t  pending_q[$];
    bar_pattern_t pattern_q[$];
    meter_item_t  cur_item;
    meter_item_t  next_item;
    logic         in_taken = 1'b0;
    int           send_idle = 0;
    int           recv_idle = 0;
    int           errors = 0;
    int           stall_cycles = 0;

    logic [31:0] cfg_total = '0;
    logic        cfg_blink = 1'b0;
    logic        cfg_round = 1'b1;
    logic [31:0] bar_count = '0;
    logic [3:0]  shown_lit = '0;

    led_bar_progress_meter_unit #(.LED_COUNT(LEDS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bar_pattern_t meter_predict(meter_item_t it);
        bar_pattern_t res;
        logic [63:0]  clamped;
        logic [63:0]  prod;
        logic [63:0]  quo;
        logic [63:0]  rem;
        logic [63:0]  lit;
        logic [63:0]  partial;
        logic         went_down;
        logic [7:0]   on_bits;
        logic [7:0]   blink_bits;
        logic         refresh;
        if (it.func == FUNC_SET)
            bar_count = it.value[32] ? 32'd0 : it.value[31:0];
        else if (it.func == FUNC_ADD)
            bar_count = bar_count + it.value[31:0];
        went_down = 1'b0;
        if (cfg_total == 32'd0)
        begin
            lit = LEDS;
        end
        else
        begin
            clamped = (bar_count < cfg_total) ? {32'd0, bar_count} : {32'd0, cfg_total};
            prod = clamped * LEDS;
            quo = prod / {32'd0, cfg_total};
            rem = prod % {32'd0, cfg_total};
            if (cfg_round)
                lit = quo + ((rem != 0) ? 64'd1 : 64'd0);
            else
                lit = quo + ((2 * rem >= {32'd0, cfg_total}) ? 64'd1 : 64'd0);
            went_down = (rem != 0) && (lit == quo);
        end
        if (went_down)
            partial = lit;
        else if (lit > 0)
            partial = lit - 1;
        else
            partial = 0;
        on_bits = '0;
        blink_bits = '0;
        if (lit > 0)
        begin
            for (int i = 0; i < LEDS; i++)
            begin
                if (cfg_blink && i == partial)
                    blink_bits[i] = 1'b1;
                else if (i < lit)
                    on_bits[i] = 1'b1;
            end
        end
        else if (cfg_blink)
        begin
            blink_bits = 8'd1;
        end
        refresh = it.force_req || (shown_lit != lit[3:0]);
        if (refresh)
            shown_lit = lit[3:0];
        res.lit_count     = lit[3:0];
        res.partial_index = partial[2:0];
        res.on_mask       = on_bits;
        res.blink_mask    = blink_bits;
        res.refreshed     = refresh;
        res.count_now     = bar_count;
        return res;
    endfunction

    function automatic meter_item_t random_item(logic [31:0] tot);
        meter_item_t it;
        int          k;
        logic [31:0] step;
        logic [31:0] delta;
        k = $urandom_range(0, 99);
        step = (tot == 32'd0) ? 32'd1000 : (tot >> 2) + 32'd1;
        delta = $urandom_range(1, step);
        it.force_req = ($urandom_range(0, 99) < 30);
        if (k < 30)
        begin
            it.func = FUNC_SET;
            if (tot == 32'd0)
                it.value = {1'b0, 32'($urandom_range(0, 20))};
            else if ($urandom_range(0, 4) == 0)
                it.value = {1'b0, tot + 32'($urandom_range(0, 3))};
            else
                it.value = {1'b0, 32'($urandom_range(0, tot))};
        end
        else if (k < 40)
        begin
            it.func = FUNC_SET;
            it.value = {2'b11, 31'($urandom)};
        end
        else if (k < 65)
        begin
            it.func = FUNC_ADD;
            if ($urandom_range(0, 1) == 0)
                it.value = {1'b0, delta};
            else
                it.value = 33'd0 - {1'b0, delta};
        end
        else if (k < 75)
        begin
            it.func = FUNC_ADD;
            if ($urandom_range(0, 1) == 0)
                it.value = {1'b0, 32'($urandom)};
            else
                it.value = {2'b11, 31'($urandom)};
        end
        else if (k < 92)
        begin
            it.func = FUNC_REFRESH;
            it.value = {1'b0, 32'($urandom)};
        end
        else
        begin
            it.func = 2'd3;
            it.value = {$urandom_range(0, 1) == 0 ? 1'b0 : 2'b11, 31'($urandom)};
        end
        return it;
    endfunction

    task automatic report(string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_TOTAL: cfg_total = data;
            REG_BLINK: cfg_blink = data[0];
            REG_ROUND: cfg_round = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_item(logic [1:0] func, logic [32:0] value, logic force_req);
        meter_item_t it;
        it.func = func;
        it.value = value;
        it.force_req = force_req;
        pending_q.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || s_tvalid || pattern_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // drive the input item and the output ready
    always @(negedge clk)
    begin
        if (!s_tvalid || in_taken)
        begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
            begin
                next_item = pending_q.pop_front();
                cur_item <= next_item;
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, next_item.value};
                s_tuser <= {next_item.force_req, next_item.func};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // check results, then predict newly taken items
    always @(posedge clk)
    begin : mon
        bar_pattern_t want;
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pattern_q.size() == 0)
            begin
                report($sformatf("unexpected item 0x%0h", m_tdata));
            end
            else
            begin
                want = pattern_q.pop_front();
                check_field("lit_count", m_tdata[3:0], want.lit_count);
                check_field("partial_index", m_tdata[6:4], want.partial_index);
                check_field("on_mask", m_tdata[14:7], want.on_mask);
                check_field("blink_mask", m_tdata[22:15], want.blink_mask);
                check_field("count_now", m_tdata[54:23], want.count_now);
                check_field("pad", m_tdata[55], 32'd0);
                check_field("refreshed", m_tuser, want.refreshed);
            end
        end
        if (rst_n && s_tvalid && s_tready)
            pattern_q.push_back(meter_predict(cur_item));
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] tot;
        logic [31:0] rand_totals [12];
        rand_totals = '{32'd1, 32'd8, 32'd100, 32'd7, 32'd3, 32'd0, 32'hFFFF_FFFF,
                        32'd9, 32'($urandom_range(1, 1000)), 32'($urandom), 32'd2, 32'd16};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            if (p < 7)
            begin
                send_idle = 26;
                recv_idle = 88;
            end
            else if (p < 11)
            begin
                send_idle = 88;
                recv_idle = 26;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (p)
                0:
                begin
                    write_reg(REG_TOTAL, 32'd0);
                    write_reg(REG_BLINK, 32'd1);
                    write_reg(REG_ROUND, 32'd1);
                    push_item(FUNC_SET, 33'd5, 1'b0);
                    push_item(FUNC_ADD, 33'd3, 1'b0);
                    push_item(FUNC_REFRESH, 33'd0, 1'b1);
                    push_item(2'd3, 33'd7, 1'b0);
                end
                1:
                begin
                    write_reg(REG_TOTAL, 32'd100);
                    write_reg(REG_BLINK, 32'd1);
                    write_reg(REG_ROUND, 32'd0);
                    push_item(FUNC_SET, 33'd0, 1'b0);
                    push_item(FUNC_SET, 33'd100, 1'b0);
                    push_item(FUNC_SET, 33'd150, 1'b0);
                    push_item(FUNC_SET, 33'h1_FFFF_FFFF, 1'b0);
                    push_item(FUNC_SET, 33'h1_8000_0000, 1'b1);
                    push_item(FUNC_SET, 33'h0_FFFF_FFFF, 1'b0);
                    push_item(FUNC_ADD, 33'd1, 1'b0);
                    push_item(FUNC_ADD, 33'h1_FFFF_FFFF, 1'b0);
                    push_item(FUNC_SET, 33'd6, 1'b0);
                    push_item(FUNC_SET, 33'd7, 1'b0);
                    push_item(FUNC_SET, 33'd56, 1'b0);
                    push_item(FUNC_REFRESH, 33'd0, 1'b1);
                    push_item(FUNC_REFRESH, 33'h0_FFFF_FFFF, 1'b0);
                    push_item(2'd3, 33'd9, 1'b1);
                end
                2:
                begin
                    write_reg(REG_TOTAL, 32'hFFFF_FFFF);
                    write_reg(REG_BLINK, 32'd0);
                    write_reg(REG_ROUND, 32'd1);
                    push_item(FUNC_SET, 33'd1, 1'b0);
                    push_item(FUNC_SET, 33'h0_FFFF_FFFE, 1'b0);
                    push_item(FUNC_SET, 33'h0_FFFF_FFFF, 1'b0);
                    push_item(FUNC_ADD, 33'h1_8000_0000, 1'b0);
                    push_item(FUNC_ADD, 33'h0_FFFF_FFFF, 1'b1);
                end
                default:
                begin
                    tot = rand_totals[p - 3];
                    write_reg(REG_TOTAL, tot);
                    write_reg(REG_BLINK, {31'd0, p[0]});
                    write_reg(REG_ROUND, {31'd0, p[1]});
                    for (int n = 0; n < RAND_ITEMS; n++)
                        pending_q.push_back(random_item(tot));
                end
            endcase
        end
        while (pending_q.size() != 0 || s_tvalid || pattern_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && pattern_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
